// ===== hw/rtl/rob_pkg.sv =====
// ----------------------------------------------------------------------------
// rob_pkg
// Shared types and constants of the rectangle overlay alpha blend unit.
// ----------------------------------------------------------------------------
package rob_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int PIX_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int REG_W   = 12;

    typedef enum logic {
        FMT_RGB = 1'b0,
        FMT_BGR = 1'b1
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_LEFT      = 3'd0,
        CFG_BOX_TOP       = 3'd1,
        CFG_BOX_WIDTH     = 3'd2,
        CFG_BOX_HEIGHT    = 3'd3,
        CFG_SCREEN_WIDTH  = 3'd4,
        CFG_SCREEN_HEIGHT = 3'd5,
        CFG_SOURCE_RGBA   = 3'd6,
        CFG_PIXEL_FORMAT  = 3'd7
    } t_cfg_idx;

    localparam logic [REG_W-1:0] RST_SCREEN_WIDTH  = 12'd1920;
    localparam logic [REG_W-1:0] RST_SCREEN_HEIGHT = 12'd1200;

    typedef struct packed {
        logic [REG_W-1:0] box_left;
        logic [REG_W-1:0] box_top;
        logic [REG_W-1:0] box_width;
        logic [REG_W-1:0] box_height;
        logic [REG_W-1:0] screen_width;
        logic [REG_W-1:0] screen_height;
        logic [PIX_W-1:0] source_rgba;
        t_fmt             pixel_format;
    } t_cfg;

endpackage

// ===== hw/rtl/rect_overlay_alpha_blend_unit.sv =====
// ----------------------------------------------------------------------------
// rect_overlay_alpha_blend_unit
// Blends a constant color rectangle into a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one destination pixel word per clock and returns one result word per
// clock while the receiver keeps ready high. An accepted pixel goes with its
// rectangle hit and frame end flags from the raster counters into the input
// register, and from there through the blend into the result register.
// The first word after reset is column 0, row 0. Write configuration only
// while no words are in flight.
module rect_overlay_alpha_blend_unit #(
    parameter int MAX_WIDTH  = rob_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rob_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rob_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rob_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [rob_pkg::PIX_W-1:0]      i_s_axis_tdata,   // [31:0] pixel_in
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [rob_pkg::PIX_W-1:0]      o_m_axis_tdata,   // [31:0] pixel_out
    output logic                           o_m_axis_tlast    // frame_end
);

    rob_pkg::t_cfg cfg;
    logic          s_acc, s1_en, out_en;
    logic          pos_inside, pos_last;
    logic [rob_pkg::PIX_W-1:0] mix_pixel;

    logic                      r_s1_valid, r_s1_inside, r_s1_last;
    logic [rob_pkg::PIX_W-1:0] r_s1_pixel;
    logic                      r_out_valid, r_out_last;
    logic [rob_pkg::PIX_W-1:0] r_out_data;

    assign o_cfg_ready = 1'b1;

    rob_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign out_en = !r_out_valid || i_m_axis_tready;
    assign s1_en  = !r_s1_valid || out_en;
    assign o_s_axis_tready = s1_en;
    assign s_acc  = i_s_axis_tvalid && s1_en;

    rob_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (s_acc),
        .o_inside (pos_inside),
        .o_last   (pos_last)
    );

    rob_mix u_mix (
        .i_cfg    (cfg),
        .i_pixel  (r_s1_pixel),
        .i_inside (r_s1_inside),
        .o_pixel  (mix_pixel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (out_en) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_pixel  <= i_s_axis_tdata;
            r_s1_inside <= pos_inside;
            r_s1_last   <= pos_last;
        end
        if (out_en && r_s1_valid) begin
            r_out_data <= mix_pixel;
            r_out_last <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== hw/rtl/rob_cfg.sv =====
// ----------------------------------------------------------------------------
// rob_cfg
// Configuration register file, one write per accepted config word.
// ----------------------------------------------------------------------------
module rob_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [rob_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rob_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output rob_pkg::t_cfg                  o_cfg
);

    rob_pkg::t_cfg r_cfg;
    rob_pkg::t_cfg n_cfg;
    logic [rob_pkg::REG_W-1:0] v12;

    assign v12 = i_cfg_data[rob_pkg::REG_W-1:0];

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (rob_pkg::t_cfg_idx'(i_cfg_index))
                rob_pkg::CFG_BOX_LEFT:      n_cfg.box_left      = v12;
                rob_pkg::CFG_BOX_TOP:       n_cfg.box_top       = v12;
                rob_pkg::CFG_BOX_WIDTH:     n_cfg.box_width     = v12;
                rob_pkg::CFG_BOX_HEIGHT:    n_cfg.box_height    = v12;
                rob_pkg::CFG_SCREEN_WIDTH:  n_cfg.screen_width  = v12;
                rob_pkg::CFG_SCREEN_HEIGHT: n_cfg.screen_height = v12;
                rob_pkg::CFG_SOURCE_RGBA:   n_cfg.source_rgba   = i_cfg_data;
                rob_pkg::CFG_PIXEL_FORMAT:  n_cfg.pixel_format  = rob_pkg::t_fmt'(i_cfg_data[0]);
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_left      <= '0;
            r_cfg.box_top       <= '0;
            r_cfg.box_width     <= '0;
            r_cfg.box_height    <= '0;
            r_cfg.screen_width  <= rob_pkg::RST_SCREEN_WIDTH;
            r_cfg.screen_height <= rob_pkg::RST_SCREEN_HEIGHT;
            r_cfg.source_rgba   <= '0;
            r_cfg.pixel_format  <= rob_pkg::FMT_BGR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/rob_pos.sv =====
// ----------------------------------------------------------------------------
// rob_pos
// Raster position counters with rectangle hit test and frame end detect.
// ----------------------------------------------------------------------------
module rob_pos #(
    parameter int MAX_WIDTH  = rob_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rob_pkg::DEF_MAX_HEIGHT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rob_pkg::t_cfg i_cfg,
    input  logic          i_step,
    output logic          o_inside,
    output logic          o_last
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int MW   = (CW > RW) ? CW : RW;
    localparam int CMPW = ((MW > rob_pkg::REG_W) ? MW : rob_pkg::REG_W) + 1;
    localparam logic [CMPW-1:0] MAX_W = CMPW'(MAX_WIDTH);
    localparam logic [CMPW-1:0] MAX_H = CMPW'(MAX_HEIGHT);

    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [CMPW-1:0] cfg_sw, cfg_sh, sw, sh;
    logic [CMPW-1:0] col_x, row_x;
    logic [CMPW-1:0] left_x, top_x, right_x, bottom_x;
    logic            row_end;

    assign cfg_sw = CMPW'(i_cfg.screen_width);
    assign cfg_sh = CMPW'(i_cfg.screen_height);
    assign sw = (cfg_sw == '0) ? CMPW'(1) : ((cfg_sw > MAX_W) ? MAX_W : cfg_sw);
    assign sh = (cfg_sh == '0) ? CMPW'(1) : ((cfg_sh > MAX_H) ? MAX_H : cfg_sh);

    assign col_x    = CMPW'(r_col);
    assign row_x    = CMPW'(r_row);
    assign left_x   = CMPW'(i_cfg.box_left);
    assign top_x    = CMPW'(i_cfg.box_top);
    assign right_x  = left_x + CMPW'(i_cfg.box_width);
    assign bottom_x = top_x + CMPW'(i_cfg.box_height);

    assign o_inside = (col_x < sw) && (row_x < sh) &&
                      (col_x >= left_x) && (col_x < right_x) &&
                      (row_x >= top_x) && (row_x < bottom_x);

    assign row_end = col_x >= (sw - CMPW'(1));
    assign o_last  = row_end && (row_x >= (sh - CMPW'(1)));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (row_end) begin
                n_col = '0;
                n_row = o_last ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== hw/rtl/rob_mix.sv =====
// ----------------------------------------------------------------------------
// rob_mix
// Per-channel constant color alpha blend with RGB/BGR byte order.
// ----------------------------------------------------------------------------
module rob_mix (
    input  rob_pkg::t_cfg              i_cfg,
    input  logic [rob_pkg::PIX_W-1:0]  i_pixel,
    input  logic                       i_inside,
    output logic [rob_pkg::PIX_W-1:0]  o_pixel
);

    function automatic logic [7:0] mix_ch(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] a);
        logic [15:0] x;
        logic [15:0] y;
        begin
            x = 16'(s) * 16'(a) + 16'(d) * (16'd255 - 16'(a));
            y = x + 16'(x[15:8]) + 16'h80;
            return y[15:8];
        end
    endfunction

    logic [7:0] a, sr, sg, sb;
    logic [7:0] d0, d1, d2, dr, db;
    logic [7:0] r_ch, g_ch, b_ch;
    logic       is_rgb;

    assign a  = i_cfg.source_rgba[7:0];
    assign sb = i_cfg.source_rgba[15:8];
    assign sg = i_cfg.source_rgba[23:16];
    assign sr = i_cfg.source_rgba[31:24];
    assign d0 = i_pixel[7:0];
    assign d1 = i_pixel[15:8];
    assign d2 = i_pixel[23:16];
    assign is_rgb = (i_cfg.pixel_format == rob_pkg::FMT_RGB);
    assign dr = is_rgb ? d0 : d2;
    assign db = is_rgb ? d2 : d0;

    always_comb begin
        if (a == 8'd255) begin
            r_ch = sr;
            g_ch = sg;
            b_ch = sb;
        end else begin
            r_ch = mix_ch(sr, dr, a);
            g_ch = mix_ch(sg, d1, a);
            b_ch = mix_ch(sb, db, a);
        end
    end

    always_comb begin
        if (i_inside && (a != 8'd0)) begin
            if (is_rgb) begin
                o_pixel = {8'd0, b_ch, g_ch, r_ch};
            end else begin
                o_pixel = {8'd0, r_ch, g_ch, b_ch};
            end
        end else begin
            o_pixel = i_pixel;
        end
    end

endmodule

// ===== hw/rtl/rob_chk.sv =====
// ----------------------------------------------------------------------------
// rob_chk
// Port-level checker for the rectangle overlay alpha blend unit.
// ----------------------------------------------------------------------------
module rob_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [rob_pkg::PIX_W-1:0]      o_m_axis_tdata,
    input logic                           o_m_axis_tlast
);

    logic s_acc;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(s_acc, 2))
        else $error("output word without an input word two cycles earlier");

    a_ready_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled while output drains");

endmodule

bind rect_overlay_alpha_blend_unit rob_chk u_rob_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rectangle overlay alpha blend unit.
// ----------------------------------------------------------------------------
// Pixel words go in on the slave stream. Every accepted word is run through a
// local raster/blend model, and the model's word goes into a queue. Each word
// on the master stream is checked against the head of that queue, both the
// pixel and the frame-end flag. Directed tests cover the corner cases first:
// opaque, partial and zero alpha, both byte orders, empty and clipped boxes,
// zero, oversized and mid-frame shrunk screens. Random small frames follow,
// with sender gaps and receiver stalls varied from phase to phase.
// Registers are written only once the stream has drained.
// ----------------------------------------------------------------------------
module tb;
    import rob_pkg::*;

    localparam int RANDOM_PIXELS  = 1875;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_W          = DEF_MAX_WIDTH;
    localparam int MAX_H          = DEF_MAX_HEIGHT;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } t_blend_result;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data      = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [PIX_W-1:0]     i_s_axis_tdata  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [PIX_W-1:0]     o_m_axis_tdata;
    logic                 o_m_axis_tlast;

    rect_overlay_alpha_blend_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // local copy of the register file and raster counters
    logic [REG_W-1:0] box_left, box_top, box_width, box_height;
    logic [REG_W-1:0] screen_width, screen_height;
    logic [PIX_W-1:0] source_rgba;
    t_fmt             pixel_format;
    int               raster_col, raster_row;

    t_blend_result pending_results[$];
    int            error_count    = 0;
    int            idle_cycles    = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] expected,
                                   input logic [PIX_W-1:0] got);
        $display("mismatch: %s expected %h got %h", what, expected, got);
        error_count++;
    endtask

    function automatic logic [7:0] blend_channel(input logic [7:0] s, input logic [7:0] d,
                                                 input logic [7:0] a);
        int unsigned x;
        x = 32'(s) * 32'(a) + 32'(d) * (32'd255 - 32'(a));
        return 8'((x + (x >> 8) + 32'h80) >> 8);
    endfunction

    function automatic logic [PIX_W-1:0] pack_color(input t_fmt fmt, input logic [7:0] r,
                                                    input logic [7:0] g, input logic [7:0] b);
        if (fmt == FMT_RGB)
            return {8'h00, b, g, r};
        return {8'h00, r, g, b};
    endfunction

    function automatic void apply_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_BOX_LEFT:      box_left      = data[REG_W-1:0];
            CFG_BOX_TOP:       box_top       = data[REG_W-1:0];
            CFG_BOX_WIDTH:     box_width     = data[REG_W-1:0];
            CFG_BOX_HEIGHT:    box_height    = data[REG_W-1:0];
            CFG_SCREEN_WIDTH:  screen_width  = data[REG_W-1:0];
            CFG_SCREEN_HEIGHT: screen_height = data[REG_W-1:0];
            CFG_SOURCE_RGBA:   source_rgba   = data;
            CFG_PIXEL_FORMAT:  pixel_format  = t_fmt'(data[0]);
            default: ;
        endcase
    endfunction

    function automatic t_blend_result predict_blend(input logic [PIX_W-1:0] px);
        int            sw, sh, col, row;
        logic [7:0]    a, dr, db;
        logic          in_box, row_end;
        t_blend_result res;
        sw = (screen_width == 0) ? 1 : (int'(screen_width) > MAX_W ? MAX_W : int'(screen_width));
        sh = (screen_height == 0) ? 1 :
             (int'(screen_height) > MAX_H ? MAX_H : int'(screen_height));
        col = raster_col;
        row = raster_row;
        a   = source_rgba[7:0];
        res.pixel = px;
        in_box = col < sw && row < sh &&
                 col >= int'(box_left) && col < int'(box_left) + int'(box_width) &&
                 row >= int'(box_top) && row < int'(box_top) + int'(box_height);
        if (in_box && a != 8'd0) begin
            if (a == 8'd255) begin
                res.pixel = pack_color(pixel_format, source_rgba[31:24], source_rgba[23:16],
                                       source_rgba[15:8]);
            end else begin
                dr = (pixel_format == FMT_RGB) ? px[7:0] : px[23:16];
                db = (pixel_format == FMT_RGB) ? px[23:16] : px[7:0];
                res.pixel = pack_color(pixel_format,
                                       blend_channel(source_rgba[31:24], dr, a),
                                       blend_channel(source_rgba[23:16], px[15:8], a),
                                       blend_channel(source_rgba[15:8], db, a));
            end
        end
        row_end       = col >= sw - 1;
        res.frame_end = row_end && row >= sh - 1;
        if (row_end) begin
            raster_col = 0;
            raster_row = res.frame_end ? 0 : row + 1;
        end else begin
            raster_col = col + 1;
        end
        return res;
    endfunction

    // returns at a falling edge with tvalid still high; any wait that follows
    // goes through drain_results, which lowers it
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= px;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_blend(px));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_box(input int left, input int top, input int w, input int h);
        write_reg(CFG_BOX_LEFT, left);
        write_reg(CFG_BOX_TOP, top);
        write_reg(CFG_BOX_WIDTH, w);
        write_reg(CFG_BOX_HEIGHT, h);
    endtask

    task automatic set_screen(input int w, input int h);
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
    endtask

    // defaults after reset: empty box, zero alpha, so everything passes
    task automatic test_reset_state();
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hA5C3_0F96);
    endtask

    // the first pixel after the shrink sits beyond the new last column
    task automatic test_opaque_fill();
        set_screen(3, 2);
        set_box(1, 0, 2, 1);
        write_reg(CFG_SOURCE_RGBA, 32'h1234_56FF);
        for (int i = 0; i < 7; i++) send_pixel({8'hFF, 24'(i * 24'h0A0B0C)});
        write_reg(CFG_PIXEL_FORMAT, 32'(FMT_RGB));
        for (int i = 0; i < 3; i++) send_pixel(32'hFF80_7F01 + i);
    endtask

    task automatic test_partial_alpha();
        set_box(0, 0, 3, 2);
        write_reg(CFG_SOURCE_RGBA, 32'hFF00_8080);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'hFFFF_FFFF);
        write_reg(CFG_SOURCE_RGBA, 32'h00FF_7F01);
        send_pixel(32'h8000_FF00);
        write_reg(CFG_PIXEL_FORMAT, 32'(FMT_BGR));
        write_reg(CFG_SOURCE_RGBA, 32'hC040_20FE);
        send_pixel(32'h0000_0000);
        send_pixel(32'h7F12_3456);
    endtask

    task automatic test_zero_alpha();
        write_reg(CFG_SOURCE_RGBA, 32'hFFFF_FF00);
        send_pixel(32'hDEAD_BEEF);
        send_pixel(32'h0102_0304);
    endtask

    // a zero screen size behaves as one: every pixel ends a frame
    task automatic test_zero_screen();
        set_screen(0, 0);
        set_box(0, 0, 1, 1);
        write_reg(CFG_SOURCE_RGBA, 32'h5566_77FF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
    endtask

    task automatic test_box_off_screen();
        set_screen(3, 2);
        set_box(3, 0, 4, 2);
        send_pixel(32'h1111_1111);
        send_pixel(32'h2222_2222);
        set_box(0, 2, 3, 5);
        send_pixel(32'h3333_3333);
        set_box(0, 0, 0, 2);
        send_pixel(32'h4444_4444);
        set_box(0, 0, 3, 0);
        send_pixel(32'h5555_5555);
    endtask

    task automatic test_screen_shrink();
        set_screen(8, 4);
        set_box(0, 0, 8, 4);
        write_reg(CFG_SOURCE_RGBA, 32'h0A0B_0C90);
        while (raster_col != 5) send_pixel($urandom);
        set_screen(2, 4);
        send_pixel(32'hFF00_FF00);
        send_pixel(32'h00FF_00FF);
        set_screen(2, 1);
        send_pixel(32'hF0F0_F0F0);
    endtask

    // sizes above the maximum saturate; a box far past the edge is clipped
    task automatic test_max_screen();
        set_screen(4095, 4095);
        set_box(0, 0, 4095, 4095);
        write_reg(CFG_SOURCE_RGBA, 32'h7788_99FF);
        repeat (20) send_pixel($urandom);
        set_screen(MAX_W + 1, 1);
        set_box(4, 0, 4095, 1);
        write_reg(CFG_SOURCE_RGBA, $urandom);
        repeat (20) send_pixel($urandom);
    endtask

    function automatic logic [CFG_DAT_W-1:0] pick_size(input int small_max);
        if ($urandom_range(9) == 0)
            return $urandom;
        return ($urandom & 32'hFFFF_F000) | $urandom_range(0, small_max);
    endfunction

    task automatic randomize_config();
        logic [7:0] alpha;
        int         sw, sh;
        sw = $urandom_range(1, 8);
        sh = $urandom_range(1, 6);
        if ($urandom_range(7) == 0) begin
            write_reg(CFG_SCREEN_WIDTH, $urandom);
            write_reg(CFG_SCREEN_HEIGHT, $urandom);
        end else begin
            write_reg(CFG_SCREEN_WIDTH, ($urandom & 32'hFFFF_F000) | sw);
            write_reg(CFG_SCREEN_HEIGHT, ($urandom & 32'hFFFF_F000) | sh);
        end
        write_reg(CFG_BOX_LEFT, pick_size(sw));
        write_reg(CFG_BOX_TOP, pick_size(sh));
        write_reg(CFG_BOX_WIDTH, pick_size(sw + 1));
        write_reg(CFG_BOX_HEIGHT, pick_size(sh + 1));
        case ($urandom_range(5))
            0: alpha = 8'h00;
            1: alpha = 8'hFF;
            2: alpha = 8'h01;
            3: alpha = 8'hFE;
            default: alpha = 8'($urandom);
        endcase
        write_reg(CFG_SOURCE_RGBA, {24'($urandom_range(0, 24'hFFFFFF)), alpha});
        write_reg(CFG_PIXEL_FORMAT, $urandom);
    endtask

    task automatic test_random_frames();
        int sent;
        int seg_len;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            case (sent * 4 / RANDOM_PIXELS)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            if ($urandom_range(9) < 6)
                randomize_config();
            else if ($urandom_range(9) == 0)
                drain_results();
            seg_len = $urandom_range(1, 60);
            repeat (seg_len) begin
                case ($urandom_range(15))
                    0: send_pixel(32'h0000_0000);
                    1: send_pixel(32'hFFFF_FFFF);
                    default: send_pixel($urandom);
                endcase
            end
            sent += seg_len;
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", '0, o_m_axis_tdata);
            end else begin
                if (o_m_axis_tdata !== pending_results[0].pixel)
                    report_mismatch("pixel_out", pending_results[0].pixel, o_m_axis_tdata);
                if (o_m_axis_tlast !== pending_results[0].frame_end)
                    report_mismatch("frame_end", 32'(pending_results[0].frame_end),
                                    32'(o_m_axis_tlast));
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake in %0d cycles", WATCHDOG_LIMIT);
            $display("** rect_overlay_alpha_blend_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        box_left      = '0;
        box_top       = '0;
        box_width     = '0;
        box_height    = '0;
        screen_width  = RST_SCREEN_WIDTH;
        screen_height = RST_SCREEN_HEIGHT;
        source_rgba   = '0;
        pixel_format  = FMT_BGR;
        raster_col    = 0;
        raster_row    = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_opaque_fill();
        test_partial_alpha();
        test_zero_alpha();
        test_zero_screen();
        test_box_off_screen();
        test_screen_shrink();
        test_max_screen();
        test_random_frames();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("words never returned", pending_results.size(), '0);
        if (error_count == 0) begin
            $display("** rect_overlay_alpha_blend_unit: PASSED **");
        end else begin
            $display("** rect_overlay_alpha_blend_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rob_pkg.sv
hw/rtl/rob_cfg.sv
hw/rtl/rob_pos.sv
hw/rtl/rob_mix.sv
hw/rtl/rect_overlay_alpha_blend_unit.sv
hw/rtl/rob_chk.sv
tb/tb.sv
